>>> design/text_console_writer_core_macros.svh
// Assertion helpers shared by the console modules.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("console check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("console check failed: next-cycle implication");

`endif

>>> design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_RETURN    = 8'd13;
	localparam logic [7:0] CODE_BACKSPACE = 8'd8;
	localparam logic [7:0] CODE_SPACE     = 8'd32;

	localparam logic [7:0] BLANK_ATTR_RESET = 8'd15;

	// paddr[2] selects the register slot; slot 0 is the blank attribute
	localparam logic REG_IDX_BLANK_ATTR = 1'b0;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		CUR_HOLD     = 3'd0,
		CUR_ADVANCE  = 3'd1,
		CUR_RETURN   = 3'd2,
		CUR_BACK     = 3'd3,
		CUR_NEXT_ROW = 3'd4,
		CUR_HOME     = 3'd5
	} cur_op_t;

	typedef struct packed {
		logic    load_item;
		cur_op_t cur_op;
		logic    calc;
		logic    wr_char;
		logic    wr_blank;
		logic    rd_cell;
		logic    sweep_all;
		logic    sweep_row;
		logic    sweep_step;
		logic    sweep_reset_attr;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  is_newline;
		logic  is_return;
		logic  is_backspace;
		logic  col_last;
		logic  row_last;
		logic  read_hit;
		logic  sweep_last;
		logic  out_free;
	} status_t;

endpackage

>>> design/tcw_datapath.sv
`timescale 1ns / 1ps

module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output status_t    status,
	input  logic [7:0] blank_attr,
	input  logic [1:0] kind,
	input  logic [7:0] char_code,
	input  logic [7:0] color,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] cell_char,
	output logic [7:0] cell_color,
	output logic [4:0] cursor_row,
	output logic [6:0] cursor_col
);

`include "text_console_writer_core_macros.svh"

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [RW:0]   ROWS_W    = (RW+1)'(ROWS);
	localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0] COLS_END  = AW'(COLUMNS - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);

	// item held for the whole of its processing
	kind_t       kind_q;
	logic [7:0]  char_q;
	logic [7:0]  color_q;
	logic [4:0]  read_row_q;
	logic [6:0]  read_col_q;

	// cursor in screen rows; top_q is the physical row shown at the top
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] top_q;

	logic [AW-1:0] addr_q;
	logic [AW-1:0] sweep_addr_q;
	logic [AW-1:0] sweep_end_q;
	logic [15:0]   rd_data_q;
	logic [15:0]   screen_q [CELLS];

	logic          out_valid_q;
	logic [7:0]    cell_char_q;
	logic [7:0]    cell_color_q;
	logic [4:0]    cursor_row_q;
	logic [6:0]    cursor_col_q;

	logic [RW-1:0] row_sel;
	logic [CW-1:0] col_sel;
	logic [RW:0]   phys_sum;
	logic [RW-1:0] phys_row;
	logic [AW-1:0] cell_addr;
	logic [AW-1:0] top_base;
	logic [RW-1:0] top_next;
	logic          read_hit;
	logic          read_ok;
	logic          sweep_last;
	logic [7:0]    fill_attr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic [27:0]   out_word;

	assign read_hit   = ({27'd0, read_row_q} < 32'(ROWS)) && ({25'd0, read_col_q} < 32'(COLUMNS));
	assign read_ok    = (kind_q == KIND_READ) && read_hit;
	assign sweep_last = (sweep_addr_q == sweep_end_q);
	assign top_base   = AW'(top_q) * COLS_A;
	assign top_next   = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;

	// map the screen row onto the rotating physical rows
	always_comb begin
		if (kind_q == KIND_READ) begin
			row_sel = RW'(read_row_q);
			col_sel = CW'(read_col_q);
		end else begin
			row_sel = row_q;
			col_sel = col_q;
		end
		phys_sum  = {1'b0, row_sel} + {1'b0, top_q};
		phys_row  = (phys_sum >= ROWS_W) ? RW'(phys_sum - ROWS_W) : RW'(phys_sum);
		cell_addr = AW'(phys_row) * COLS_A + AW'(col_sel);
	end

	always_comb begin
		fill_attr = cmd.sweep_reset_attr ? BLANK_ATTR_RESET : blank_attr;
		wr_en     = cmd.wr_char | cmd.wr_blank | cmd.sweep_step;
		wr_addr   = cmd.sweep_step ? sweep_addr_q : addr_q;
		wr_data   = cmd.wr_char ? {color_q, char_q} : {fill_attr, CODE_SPACE};
	end

	always_comb begin
		status              = '0;
		status.kind         = kind_q;
		status.is_newline   = (char_q == CODE_NEWLINE);
		status.is_return    = (char_q == CODE_RETURN);
		status.is_backspace = (char_q == CODE_BACKSPACE);
		status.col_last     = (col_q == COL_LAST);
		status.row_last     = (row_q == ROW_LAST);
		status.read_hit     = read_hit;
		status.sweep_last   = sweep_last;
		status.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= KIND_WRITE;
			char_q     <= '0;
			color_q    <= '0;
			read_row_q <= '0;
			read_col_q <= '0;
		end else if (cmd.load_item) begin
			kind_q     <= kind_t'(kind);
			char_q     <= char_code;
			color_q    <= color;
			read_row_q <= read_row;
			read_col_q <= read_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.calc) begin
			addr_q <= cell_addr;
		end
	end

	// scroll by advancing the top row instead of moving cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			top_q <= '0;
		end else begin
			unique case (cmd.cur_op)
				CUR_HOLD: ;
				CUR_ADVANCE: col_q <= col_q + 1'b1;
				CUR_RETURN: col_q <= '0;
				CUR_BACK: begin
					if (col_q != '0) begin
						col_q <= col_q - 1'b1;
					end else if (row_q != '0) begin
						row_q <= row_q - 1'b1;
						col_q <= COL_LAST;
					end
				end
				CUR_NEXT_ROW: begin
					col_q <= '0;
					if (row_q == ROW_LAST) begin
						top_q <= top_next;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				CUR_HOME: begin
					row_q <= '0;
					col_q <= '0;
					top_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// sweep the whole screen, or the row leaving the top, which becomes the new bottom row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
			sweep_end_q  <= CELL_LAST;
		end else if (cmd.sweep_all) begin
			sweep_addr_q <= '0;
			sweep_end_q  <= CELL_LAST;
		end else if (cmd.sweep_row) begin
			sweep_addr_q <= top_base;
			sweep_end_q  <= top_base + COLS_END;
		end else if (cmd.sweep_step && !sweep_last) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			screen_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_cell) begin
			rd_data_q <= screen_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			cell_char_q  <= '0;
			cell_color_q <= '0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
		end else if (cmd.out_load) begin
			out_valid_q  <= 1'b1;
			cell_char_q  <= read_ok ? rd_data_q[7:0] : 8'd0;
			cell_color_q <= read_ok ? rd_data_q[15:8] : 8'd0;
			cursor_row_q <= 5'(row_q);
			cursor_col_q <= 7'(col_q);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_word   = {cell_char_q, cell_color_q, cursor_row_q, cursor_col_q};
	assign out_valid  = out_valid_q;
	assign cell_char  = cell_char_q;
	assign cell_color = cell_color_q;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

	`TCW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !out_ready, out_valid_q)
	`TCW_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid_q && !out_ready, $stable(out_word))
	`TCW_ASSERT_IMPL(a_cursor_range, clk, arst_n, 1'b1, (row_q <= ROW_LAST) && (col_q <= COL_LAST))
	`TCW_ASSERT_IMPL(a_sweep_bound, clk, arst_n, 1'b1, sweep_addr_q <= sweep_end_q)

endmodule

>>> design/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

`include "text_console_writer_core_macros.svh"

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_DECODE = 7'b0000100,
		S_CALC   = 7'b0001000,
		S_ACCESS = 7'b0010000,
		S_SWEEP  = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				// blank the whole screen with the reset attribute
				cmd.sweep_step       = 1'b1;
				cmd.sweep_reset_attr = 1'b1;
				if (status.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.kind)
					KIND_WRITE: begin
						if (status.is_newline) begin
							cmd.cur_op = CUR_NEXT_ROW;
							if (status.row_last) begin
								cmd.sweep_row = 1'b1;
								state_d       = S_SWEEP;
							end else begin
								state_d = S_FINISH;
							end
						end else if (status.is_return) begin
							cmd.cur_op = CUR_RETURN;
							state_d    = S_FINISH;
						end else if (status.is_backspace) begin
							cmd.cur_op = CUR_BACK;
							state_d    = S_CALC;
						end else begin
							state_d = S_CALC;
						end
					end
					KIND_CLEAR: begin
						cmd.cur_op    = CUR_HOME;
						cmd.sweep_all = 1'b1;
						state_d       = S_SWEEP;
					end
					KIND_READ: begin
						state_d = status.read_hit ? S_CALC : S_FINISH;
					end
					KIND_NONE: begin
						state_d = S_FINISH;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_ACCESS;
			end
			S_ACCESS: begin
				state_d = S_FINISH;
				if (status.kind == KIND_READ) begin
					cmd.rd_cell = 1'b1;
				end else if (status.is_backspace) begin
					cmd.wr_blank = 1'b1;
				end else begin
					cmd.wr_char = 1'b1;
					if (status.col_last) begin
						cmd.cur_op = CUR_NEXT_ROW;
						if (status.row_last) begin
							cmd.sweep_row = 1'b1;
							state_d       = S_SWEEP;
						end
					end else begin
						cmd.cur_op = CUR_ADVANCE;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (status.sweep_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				// hold until the output register can take the word
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	`TCW_ASSERT_NEXT(a_accept_decode, clk, arst_n, in_valid && in_ready, state_q == S_DECODE)
	`TCW_ASSERT_NEXT(a_sweep_hold, clk, arst_n, (state_q == S_SWEEP) && !status.sweep_last, state_q == S_SWEEP)
	`TCW_ASSERT_NEXT(a_finish_release, clk, arst_n, (state_q == S_FINISH) && status.out_free, state_q == S_IDLE)

endmodule

>>> design/text_console_writer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Word
// input     in         in_valid / in_ready    kind, char_code, color, read_row, read_col
// output    out        out_valid / out_ready  cell_char, cell_color, cursor_row, cursor_col
// config    in         psel / penable / pready  paddr, pwdata, pwrite, prdata
//
// One item at a time: a printable character, a backspace or a read inside the screen passes
// through the decode, calc, access and finish states; newline, carriage return, a read
// outside the screen and the unused kind go from decode to finish. A newline or a wrap on
// the bottom row adds a sweep that blanks the row that scrolls in; a clear sweeps all
// ROWS*COLUMNS cells, one cell per cycle through the single write port of the screen RAM.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with in_ready low.
// The next item is accepted while a result waits in the output register; a word held
// there stalls the following item only in its finish state.

module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  char_code,
	input  logic [7:0]  color,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_color,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cmd_t       cmd;
	status_t    status;
	logic [7:0] blank_attr_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_BLANK_ATTR) ? {24'd0, blank_attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= BLANK_ATTR_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == REG_IDX_BLANK_ATTR)) begin
			blank_attr_q <= pwdata[7:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.blank_attr (blank_attr_q),
		.kind       (kind),
		.char_code  (char_code),
		.color      (color),
		.read_row   (read_row),
		.read_col   (read_col),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_char  (cell_char),
		.cell_color (cell_color),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col)
	);

endmodule
